// ----- rtl/rsa_pkg.sv -----
// Shared types and constants for the ripple slot allocator.
`default_nettype none
package rsa_pkg;

   localparam int SLOTS = 4;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam int ID_W   = 32;
   localparam int TIME_W = 48;
   localparam int DUR_W  = 16;
   localparam int MASK_W = 4;
   localparam int SIDX_W = 2;

   localparam logic [DUR_W-1:0] DUR_MIN   = DUR_W'(500);
   localparam logic [DUR_W-1:0] DUR_RESET = DUR_W'(2000);

   localparam logic FUNC_ACTIVATE = 1'b0;
   localparam logic FUNC_TICK     = 1'b1;

   typedef enum logic [2:0] {
      STAT_ZERO   = 3'd0,
      STAT_DUP    = 3'd1,
      STAT_FREE   = 3'd2,
      STAT_OLDEST = 3'd3,
      STAT_TICK   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic              func;
      logic [ID_W-1:0]   event_id;
      logic [TIME_W-1:0] event_start_ms;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [SIDX_W-1:0] slot_index;
      logic [MASK_W-1:0] active_mask;
      logic [MASK_W-1:0] expired_mask;
   } rsp_type;

endpackage
`default_nettype wire

// ----- rtl/rsa_req_if.sv -----
// Request channel interface.
`default_nettype none
interface rsa_req_if;
   import rsa_pkg::*;

   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- rtl/rsa_rsp_if.sv -----
// Response channel interface.
`default_nettype none
interface rsa_rsp_if;
   import rsa_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- rtl/ripple_slot_allocator.sv -----
// Slot allocator top level: slot table, walk sequencer and response register.
// Requests are accepted only in idle; a zero-id activate skips the slot walk and goes
//   straight to finish. One slot is visited per cycle by the shared compare unit, and the
//   response register frees the input side, though finish waits while a held response is unread.
// Reset: slot active bits and event ids clear, duration returns to 2000 ms, no clearing pass.
`default_nettype none
module ripple_slot_allocator (
   input  wire logic                      clock,
   input  wire logic                      reset,
   rsa_req_if.sink                        req_if,
   rsa_rsp_if.source                      rsp_if,
   input  wire logic                      csr_we,
   input  wire logic [rsa_pkg::DUR_W-1:0] csr_wdata
);
   import rsa_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   state_type state_ff, state_in;

   logic [DUR_W-1:0]  dur_ff, dur_in;
   logic [SLOTS-1:0]  act_ff, act_in;
   logic [ID_W-1:0]   ids_ff   [SLOTS];
   logic [TIME_W-1:0] starts_ff[SLOTS];

   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              func_ff, func_in;
   logic              zero_ff, zero_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [TIME_W-1:0] start_ff, start_in;
   logic [TIME_W:0]   thresh_ff, thresh_in;
   logic              dup_ff, dup_in;
   logic              free_ff, free_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic [TIME_W:0]   oldest_ff, oldest_in;
   logic [IDX_W-1:0]  old_idx_ff, old_idx_in;
   logic [SLOTS-1:0]  exp_ff, exp_in;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              accept, scan_en, out_free, commit;
   logic              s_act, id_hit, older, late;
   logic [ID_W-1:0]   s_id;
   logic [TIME_W-1:0] s_start;
   logic [DUR_W-1:0]  dur_eff;
   logic [IDX_W-1:0]  target;
   logic              do_write;
   logic [SLOTS-1:0]  act_next;
   status_type        status;

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign accept   = req_if.valid && req_if.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_if.payload.func == FUNC_ACTIVATE && req_if.payload.event_id == '0)
                  state_in = ST_FINISH;
               else
                  state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (idx_ff == LAST_IDX) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_if.ready = 1'b0;
      scan_en      = 1'b0;
      commit       = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_if.ready = 1'b1;
         ST_SCAN:   scan_en      = 1'b1;
         ST_FINISH: commit       = out_free;
         default: ;
      endcase
   end

   // shared compare unit on the slot under the walk pointer
   assign s_act   = act_ff[idx_ff];
   assign s_id    = ids_ff[idx_ff];
   assign s_start = starts_ff[idx_ff];
   assign id_hit  = (s_id == id_ff);
   assign older   = ({1'b0, s_start} < oldest_ff);
   // thresh = now - duration, so elapsed > duration reduces to thresh > start
   assign late    = ($signed(thresh_ff) > $signed({1'b0, s_start}));

   assign dur_eff = (dur_ff < DUR_MIN) ? DUR_MIN : dur_ff;

   assign target   = free_ff ? free_idx_ff : old_idx_ff;
   assign do_write = (func_ff == FUNC_ACTIVATE) && !zero_ff && !dup_ff;

   always_comb begin
      act_next = act_ff;
      if (do_write) act_next[target] = 1'b1;
   end

   always_comb begin
      if (func_ff == FUNC_TICK) status = STAT_TICK;
      else if (zero_ff)         status = STAT_ZERO;
      else if (dup_ff)          status = STAT_DUP;
      else if (free_ff)         status = STAT_FREE;
      else                      status = STAT_OLDEST;
   end

   always_comb begin
      dur_in       = csr_we ? csr_wdata : dur_ff;
      act_in       = act_ff;
      idx_in       = idx_ff;
      func_in      = func_ff;
      zero_in      = zero_ff;
      id_in        = id_ff;
      start_in     = start_ff;
      thresh_in    = thresh_ff;
      dup_in       = dup_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      oldest_in    = oldest_ff;
      old_idx_in   = old_idx_ff;
      exp_in       = exp_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_if.ready ? 1'b0 : rsp_valid_ff;

      if (accept) begin
         idx_in      = '0;
         func_in     = req_if.payload.func;
         zero_in     = (req_if.payload.event_id == '0);
         id_in       = req_if.payload.event_id;
         start_in    = (req_if.payload.event_start_ms == '0) ?
                       req_if.payload.now_ms : req_if.payload.event_start_ms;
         thresh_in   = {1'b0, req_if.payload.now_ms} - (TIME_W+1)'(dur_eff);
         dup_in      = 1'b0;
         free_in     = 1'b0;
         free_idx_in = '0;
         oldest_in   = '1;
         old_idx_in  = '0;
         exp_in      = '0;
      end

      if (scan_en) begin
         idx_in = idx_ff + IDX_W'(1);
         if (func_ff == FUNC_TICK) begin
            if (s_act && late) begin
               exp_in[idx_ff] = 1'b1;
               act_in[idx_ff] = 1'b0;
            end
         end else begin
            if (id_hit) dup_in = 1'b1;
            if (!free_ff) begin
               if (!s_act) begin
                  free_in     = 1'b1;
                  free_idx_in = idx_ff;
               end else if (older) begin
                  oldest_in  = {1'b0, s_start};
                  old_idx_in = idx_ff;
               end
            end
         end
      end

      if (commit) begin
         act_in            = act_next;
         rsp_valid_in      = 1'b1;
         rsp_in.status     = status;
         rsp_in.slot_index = do_write ? SIDX_W'(target) : '0;
         rsp_in.active_mask  = '0;
         rsp_in.expired_mask = '0;
         for (int i = 0; i < MASK_W; i++) begin
            if (i < SLOTS) begin
               rsp_in.active_mask[i]  = act_next[i];
               rsp_in.expired_mask[i] = exp_ff[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dur_ff       <= DUR_RESET;
         act_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dur_ff       <= dur_in;
         act_ff       <= act_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      zero_ff     <= zero_in;
      id_ff       <= id_in;
      start_ff    <= start_in;
      thresh_ff   <= thresh_in;
      dup_ff      <= dup_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      oldest_ff   <= oldest_in;
      old_idx_ff  <= old_idx_in;
      exp_ff      <= exp_in;
      rsp_ff      <= rsp_in;
   end

   // slot payload table, written once per committed activate that is neither zero-id nor a duplicate
   // ids clear on reset since the duplicate check also looks at idle slots
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) ids_ff[i] <= '0;
      end else if (commit && do_write) begin
         ids_ff[target]    <= id_ff;
         starts_ff[target] <= start_ff;
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

   a_tick_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == STAT_TICK |->
         (rsp_ff.expired_mask & rsp_ff.active_mask) == '0)
      else $error("expired slot still reported active");

   a_act_no_expire: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != STAT_TICK |-> rsp_ff.expired_mask == '0)
      else $error("activate reported expired slots");

   a_write_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.status == STAT_FREE || rsp_ff.status == STAT_OLDEST) |->
         rsp_ff.active_mask[rsp_ff.slot_index])
      else $error("written slot not active");

   a_oldest_full: assert property (@(posedge clock) disable iff (reset)
      commit && status == STAT_OLDEST |-> act_ff == '1)
      else $error("replacement while a slot was free");

   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |=> !accept)
      else $error("request accepted during slot walk");

endmodule
`default_nettype wire
